@@ rtl/tccw_pkg.sv @@
// Shared types, constants and codes of the text console cell writer.
`default_nettype none

package tccw_pkg;

	// Frame geometry.
	localparam int LINE_WIDTH = 80;
	localparam int LINE_COUNT = 25;
	localparam int TAB_STEP   = 4;
	localparam int CELLS      = LINE_WIDTH * LINE_COUNT;

	// Widths of the cursor state, derived from the geometry.
	localparam int COL_W  = $clog2(LINE_WIDTH);
	localparam int ROW_W  = $clog2(LINE_COUNT);
	localparam int POS_W  = $clog2(CELLS);
	localparam int LEFT_W = $clog2(CELLS + 1);

	// Field widths of the stream items.
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 11;
	localparam int ADDR_W  = 12;
	localparam int ATTR_W  = 8;
	localparam int CURS_W  = 11;
	localparam int COUNT_W = 11;
	localparam int COLOR_W = 4;

	// Widest operand of the budget clip.
	localparam int CLIP_W = (LEFT_W > LEN_W) ? LEFT_W : LEN_W;

	// Packed stream widths.
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 56;
	localparam int M_USER_W = 2;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;
	localparam logic [COLOR_W-1:0]   FG_RESET       = 4'd8;
	localparam logic [COLOR_W-1:0]   BG_RESET       = 4'd2;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_END     = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

	// Queue between front and back; depth is two, so one pointer bit.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Class of a character as decided by the front.
	typedef enum logic [1:0] {
		KIND_END,
		KIND_NEWLINE,
		KIND_TAB,
		KIND_PRINT
	} kind_t;

	// One classified request waiting for the back.
	typedef struct packed {
		logic              start;
		kind_t             kind;
		logic [CHAR_W-1:0] char_code;
		logic [LEN_W-1:0]  request_length;
	} qent_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic valid;
	} qstat_t;

endpackage

`default_nettype wire

@@ rtl/tccw_front.sv @@
// Front end: takes requests from the input stream and classifies the character.
`default_nettype none

module tccw_front import tccw_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // char_code[7:0], request_length[18:8]
	input  wire logic                s_tuser,   // start_write
	input  wire qstat_t              qstat,
	output logic                     push,
	output qent_t                    push_data
);

	logic [CHAR_W-1:0] ch;
	kind_t             kind;
	logic              seen_q;

	assign ch = s_tdata[CHAR_W-1:0];

	// Classify the character for the back end.
	always_comb begin
		priority if (ch == CH_END) begin
			kind = KIND_END;
		end else if (ch == CH_NEWLINE) begin
			kind = KIND_NEWLINE;
		end else if (ch == CH_TAB) begin
			kind = KIND_TAB;
		end else begin
			kind = KIND_PRINT;
		end
	end

	// Ready while the queue has room; reset holds the input off until seen_q is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign s_tready = seen_q && !qstat.full;
	assign push     = s_tvalid && s_tready;

	assign push_data.start          = s_tuser;
	assign push_data.kind           = kind;
	assign push_data.char_code      = ch;
	assign push_data.request_length = s_tdata[CHAR_W +: LEN_W];

endmodule

`default_nettype wire

@@ rtl/tccw_queue.sv @@
// Short queue of classified requests between the front and the back.
`default_nettype none

module tccw_queue import tccw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_data,
	input  wire logic  pop,
	output qent_t      head,
	output qstat_t     qstat
);

	qent_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head        = slot_q[rd_ptr_q];
	assign qstat.valid = (count_q != '0);
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

@@ rtl/tccw_back.sv @@
// Back end: cursor, budget and colors; builds each result into the output register.
`default_nettype none

module tccw_back import tccw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire qent_t                head,
	input  wire qstat_t               qstat,
	output logic                      pop,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_DATA_W-1:0]       m_tdata,
	output logic [M_USER_W-1:0]       m_tuser,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data
);

	// Architectural state.
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [LEN_W-1:0]   budget_q;
	logic               stopped_q;
	logic [COUNT_W-1:0] consumed_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	// Output register.
	logic                out_valid_q;
	logic                accepted_q;
	logic                wrote_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CHAR_W-1:0]   char_q;
	logic [ATTR_W-1:0]   attr_q;
	logic [CURS_W-1:0]   curs_q;
	logic [COUNT_W-1:0]  count_q;

	// Step logic.
	logic [POS_W-1:0]   pos;
	logic [LEFT_W-1:0]  left;
	logic [LEN_W-1:0]   clip;
	logic [LEN_W-1:0]   budget_eff;
	logic               stopped_eff;
	logic [COUNT_W-1:0] consumed_eff;
	logic               consume;
	logic [COL_W:0]     col_sum;
	logic               col_wrap;
	logic               row_inc;
	logic [COL_W-1:0]   col_n;
	logic [ROW_W-1:0]   row_n;
	logic [LEN_W-1:0]   budget_n;
	logic [COUNT_W-1:0] consumed_n;
	logic [POS_W-1:0]   pos_n;
	logic               wrote;

	// Linear position and cells left to the end of the frame.
	assign pos  = POS_W'(row_q) * POS_W'(LINE_WIDTH) + POS_W'(col_q);
	assign left = LEFT_W'(CELLS) - LEFT_W'(pos);
	assign clip = (CLIP_W'(head.request_length) < CLIP_W'(left)) ?
		head.request_length : LEN_W'(left);

	// A start opens a new write before the character is handled.
	assign budget_eff   = head.start ? clip : budget_q;
	assign stopped_eff  = head.start ? 1'b0 : stopped_q;
	assign consumed_eff = head.start ? '0 : consumed_q;
	assign consume      = !stopped_eff && (head.kind != KIND_END) && (budget_eff != '0);
	assign wrote        = consume && (head.kind == KIND_PRINT);

	// Column advance by one or by a tab step, with a single wrap.
	assign col_sum  = (COL_W + 1)'(col_q) +
		((head.kind == KIND_TAB) ? (COL_W + 1)'(TAB_STEP) : (COL_W + 1)'(1));
	assign col_wrap = (col_sum >= (COL_W + 1)'(LINE_WIDTH));

	// Next cursor; a newline or a column wrap moves down one row, the last row wraps to the top.
	always_comb begin
		col_n   = col_q;
		row_inc = 1'b0;
		if (consume) begin
			unique case (head.kind)
				KIND_NEWLINE: begin
					col_n   = '0;
					row_inc = 1'b1;
				end
				KIND_TAB, KIND_PRINT: begin
					col_n   = col_wrap ? COL_W'(col_sum - (COL_W + 1)'(LINE_WIDTH))
						: COL_W'(col_sum);
					row_inc = col_wrap;
				end
				default: begin
					col_n   = col_q;
					row_inc = 1'b0;
				end
			endcase
		end
		if (row_inc) begin
			row_n = (row_q == ROW_W'(LINE_COUNT - 1)) ? '0 : row_q + 1'b1;
		end else begin
			row_n = row_q;
		end
	end

	assign budget_n   = consume ? budget_eff - 1'b1 : budget_eff;
	assign consumed_n = consume ? consumed_eff + 1'b1 : consumed_eff;
	assign pos_n      = POS_W'(row_n) * POS_W'(LINE_WIDTH) + POS_W'(col_n);

	// The queue head moves on when the output register is free or being emptied.
	assign pop = qstat.valid && (!out_valid_q || m_tready);

	// Cursor, budget and write state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			budget_q   <= '0;
			stopped_q  <= 1'b1;
			consumed_q <= '0;
		end else if (pop) begin
			col_q      <= col_n;
			row_q      <= row_n;
			budget_q   <= budget_n;
			stopped_q  <= !consume;
			consumed_q <= consumed_n;
		end
	end

	// Color registers from the configuration port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FOREGROUND: fg_q <= cfg_data;
				REG_BACKGROUND: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			accepted_q <= consume;
			wrote_q    <= wrote;
			addr_q     <= ADDR_W'({pos, 1'b0});
			char_q     <= wrote ? head.char_code : '0;
			attr_q     <= wrote ? {bg_q, fg_q} : '0;
			curs_q     <= CURS_W'(pos_n);
			count_q    <= consumed_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {wrote_q, accepted_q};
	assign m_tdata  = {6'd0, count_q, curs_q, attr_q, char_q, addr_q};

endmodule

`default_nettype wire

@@ rtl/text_console_cell_writer.sv @@
// Top level of the text console cell writer.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  input    | s_tvalid / s_tready  | s_tdata: char_code, request_length; s_tuser: start_write
//  output   | m_tvalid / m_tready  | m_tdata: address, char, attribute, cursor, count;
//           |                      | m_tuser: accepted, cell_write
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data (color nibble)
//
// One request is taken every cycle while s_tready is high; each gives one result, which
// passes through the queue and is registered in the output register before it is taken.
// A two-entry queue decouples the classifying front from the cursor logic, so the
// input takes two more requests while a finished result waits on m_tready, then
// s_tready drops until the result is taken.
// Reset is asynchronous and active low; after it s_tready stays low until seen_q is set.
// Configuration writes are taken every cycle.
`default_nettype none

module text_console_cell_writer import tccw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_DATA_W-1:0]  s_tdata,   // char_code[7:0], request_length[18:8]
	input  wire logic                 s_tuser,   // start_write
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// cell_address[11:0], cell_char[19:12], cell_attribute[27:20],
	// cursor_position[38:28], consumed_count[49:39]
	output logic [M_DATA_W-1:0]       m_tdata,
	output logic [M_USER_W-1:0]       m_tuser,   // accepted[0], cell_write[1]
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data
);

	qstat_t qstat;
	qent_t  push_data;
	qent_t  head;
	logic   push;
	logic   pop;

	// Front: accept and classify.
	tccw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between the two halves.
	tccw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back: cursor update and result register.
	tccw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

@@ rtl/tccw_checker.sv @@
// Port-level checks of the text console cell writer, bound to the top level.
`default_nettype none

module tccw_checker import tccw_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [M_USER_W-1:0] m_tuser
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A cell is only written for a consumed character.
	a_write_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("cell written without acceptance");

	// Character and attribute are zero when no cell is written.
	a_blank_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[27:12] == 16'd0)
		else $error("cell payload without a cell write");

	// A written cell never holds a control character.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[19:12] != CH_END &&
			m_tdata[19:12] != CH_NEWLINE && m_tdata[19:12] != CH_TAB)
		else $error("control character written to a cell");

	// An accepted character is counted in the current write.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[49:39] != 11'd0)
		else $error("accepted character not counted");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/text_console_cell_writer_tb.sv @@
// Self-checking testbench of the text console cell writer.
`default_nettype none

module text_console_cell_writer_tb;
	import tccw_pkg::*;

	// Cycle count at which a hung run is abandoned.
	localparam int CYCLE_LIMIT = 300000;
	// Step of the running request total that ends each of the five random phases.
	localparam int PHASE_ITEMS = 270;

	// Fields of one result, in the order they are checked.
	typedef struct packed {
		logic               accepted;
		logic               cell_write;
		logic [ADDR_W-1:0]  cell_address;
		logic [CHAR_W-1:0]  cell_char;
		logic [ATTR_W-1:0]  cell_attribute;
		logic [CURS_W-1:0]  cursor_position;
		logic [COUNT_W-1:0] consumed_count;
	} cell_result_t;

	// Tracks the cursor and write state and keeps the cell results still to come.
	class cell_tracker;
		logic [COLOR_W-1:0] fg_color = FG_RESET;
		logic [COLOR_W-1:0] bg_color = BG_RESET;
		logic [COL_W-1:0]   col      = '0;
		logic [ROW_W-1:0]   row      = '0;
		logic [LEN_W-1:0]   budget   = '0;
		logic [COUNT_W-1:0] consumed = '0;
		bit                 stopped  = 1'b1;
		cell_result_t       pending_cells[$];
		int                 failures = 0;

		function void set_color(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
			if (idx == REG_FOREGROUND) begin
				fg_color = value;
			end else begin
				bg_color = value;
			end
		endfunction

		// Works out the result of one accepted request; returns 0 if the block ignores it.
		function bit predict_cell(bit start, logic [CHAR_W-1:0] ch, logic [LEN_W-1:0] len);
			cell_result_t r;
			int pos;
			int left;
			int c;
			int w;
			bit live;
			pos = int'(row) * LINE_WIDTH + int'(col);
			r = '0;
			r.cell_address = ADDR_W'(pos * 2);
			live = start || !stopped;
			// A new write clips its length to the cells left in the frame.
			if (start) begin
				left = CELLS - pos;
				budget = (int'(len) < left) ? len : LEN_W'(left);
				consumed = '0;
				stopped = 1'b0;
			end
			if (!stopped) begin
				if (ch == CH_END || budget == '0) begin
					stopped = 1'b1;
				end else begin
					c = col;
					w = row;
					r.accepted = 1'b1;
					budget--;
					consumed++;
					if (ch == CH_NEWLINE) begin
						w++;
						c = 0;
					end else if (ch == CH_TAB) begin
						c += TAB_STEP;
					end else begin
						c++;
						r.cell_write = 1'b1;
						r.cell_char = ch;
						r.cell_attribute = {bg_color, fg_color};
					end
					// Column overflow moves down a row; the last row wraps to the top.
					if (c >= LINE_WIDTH) begin
						c = c % LINE_WIDTH;
						w++;
					end
					if (w >= LINE_COUNT) begin
						w = w % LINE_COUNT;
					end
					col = COL_W'(c);
					row = ROW_W'(w);
				end
			end
			r.cursor_position = CURS_W'(int'(row) * LINE_WIDTH + int'(col));
			r.consumed_count = consumed;
			pending_cells.push_back(r);
			return live;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch in %s: expected %0d, got %0d", name, want, got);
				end
			end
		endfunction

		// Compares one result taken from the block with the oldest expected cell.
		function void check_cell(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
			cell_result_t want;
			if (pending_cells.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected result: data %h user %b", data, user);
				end
				return;
			end
			want = pending_cells.pop_front();
			compare_field("accepted", want.accepted, user[0]);
			compare_field("cell_write", want.cell_write, user[1]);
			compare_field("cell_address", want.cell_address, data[11:0]);
			compare_field("cell_char", want.cell_char, data[19:12]);
			compare_field("cell_attribute", want.cell_attribute, data[27:20]);
			compare_field("cursor_position", want.cursor_position, data[38:28]);
			compare_field("consumed_count", want.consumed_count, data[49:39]);
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;   // char_code[7:0], request_length[18:8]
	logic                 s_tuser   = 1'b0; // start_write
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;          // address, char, attribute, cursor, count
	logic [M_USER_W-1:0]  m_tuser;          // accepted[0], cell_write[1]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COLOR_W-1:0]   cfg_data  = '0;

	cell_tracker tracker = new;
	int          cycles      = 0;
	int          sent_items  = 0;
	int          long_hold   = 0;
	bit          full_rate   = 1'b0;

	text_console_cell_writer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Abandon a run that goes past the cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Check every result the block hands over.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_cell(m_tdata, m_tuser);
		end
	end

	// Result side: random stalls per result unless at full rate, plus one long hold-off.
	initial begin
		int stall;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			stall = full_rate ? 0 : $urandom_range(0, 3);
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(bit start, logic [CHAR_W-1:0] ch, logic [LEN_W-1:0] len);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= start;
		s_tdata <= {{(S_DATA_W - CHAR_W - LEN_W){1'b0}}, len, ch};
		do @(posedge clk); while (!s_tready);
		void'(tracker.predict_cell(start, ch, len));
		sent_items++;
	endtask

	// Stops offering and waits until every expected result has come.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_cells.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both color registers; the block is idle when this is called.
	task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FOREGROUND;
		cfg_data <= fg;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_color(REG_FOREGROUND, fg);
		cfg_index <= REG_BACKGROUND;
		cfg_data <= bg;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_color(REG_BACKGROUND, bg);
		cfg_valid <= 1'b0;
	endtask

	// Character mix; a bias mode makes newlines or tabs dominate so the cursor roams.
	function automatic logic [CHAR_W-1:0] pick_char(int bias);
		int r;
		r = $urandom_range(0, 99);
		if (bias == 1 && r < 50) return CH_NEWLINE;
		if (bias == 2 && r < 60) return CH_TAB;
		if (r < 6) return CH_NEWLINE;
		if (r < 10) return CH_TAB;
		if (r < 12) return CH_END;
		return CHAR_W'($urandom_range(1, 255));
	endfunction

	// One write: a start request with a random length, then its characters and at times stray requests.
	task automatic random_write();
		int r;
		int count;
		int bias;
		logic [LEN_W-1:0] len;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			len = '0;
		end else if (r < 10) begin
			len = '1;
		end else if (r < 20) begin
			len = LEN_W'($urandom_range(0, 2047));
		end else begin
			len = LEN_W'($urandom_range(1, 60));
		end
		count = $urandom_range(0, 50);
		bias = $urandom_range(0, 9);
		full_rate = ($urandom_range(0, 4) == 0);
		send_request(1'b1, pick_char(bias), len);
		repeat (count) send_request(1'b0, pick_char(bias), LEN_W'($urandom_range(0, 2047)));
		// Stray requests after the write; the block ignores them if the write has stopped.
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				send_request(1'b0, CHAR_W'($urandom_range(0, 255)),
					LEN_W'($urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset colors.
		send_request(1'b0, 8'h41, 11'd5);       // ignored: nothing active after reset
		send_request(1'b1, 8'h41, 11'd0);       // zero length stops at once
		send_request(1'b0, 8'h42, 11'd0);       // ignored
		send_request(1'b1, CH_END, 11'd100);    // terminator on the first character
		send_request(1'b1, 8'h48, 11'h7FF);     // longest request, clipped to the frame
		send_request(1'b0, 8'hFF, 11'h7FF);
		send_request(1'b0, 8'h01, 11'd0);
		send_request(1'b0, CH_TAB, 11'd0);
		send_request(1'b0, CH_NEWLINE, 11'd0);
		send_request(1'b0, 8'h80, 11'h555);
		send_request(1'b0, CH_END, 11'd0);      // terminator mid-write
		send_request(1'b0, 8'h78, 11'd0);       // ignored after the terminator
		send_request(1'b1, 8'h61, 11'd3);       // budget of three runs out
		send_request(1'b0, 8'h62, 11'h2AA);
		send_request(1'b0, 8'h63, 11'd0);
		send_request(1'b0, 8'h64, 11'd0);       // budget exhausted
		send_request(1'b1, CH_NEWLINE, 11'd10);
		send_request(1'b0, CH_TAB, 11'd0);

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: begin
						fg = 4'd0;
						bg = 4'd0;
					end
					2: begin
						fg = 4'd15;
						bg = 4'd15;
					end
					3: begin
						fg = 4'd15;
						bg = 4'd0;
					end
					default: begin
						fg = COLOR_W'($urandom_range(0, 15));
						bg = COLOR_W'($urandom_range(0, 15));
					end
				endcase
				set_colors(fg, bg);
			end
			// Back-to-back requests against a long hold-off fill the block.
			if (phase == 2) begin
				full_rate = 1'b1;
				long_hold = 80;
				send_request(1'b1, 8'h5A, 11'd40);
				repeat (30) send_request(1'b0, CHAR_W'($urandom_range(1, 255)), 11'd0);
			end
			while (sent_items < (phase + 1) * PHASE_ITEMS) begin
				random_write();
				// Mid-phase, pause after each write inside a window of the sent count until the block has emptied.
				if (phase == 3 && sent_items >= 4 * PHASE_ITEMS - 130 &&
					sent_items < 4 * PHASE_ITEMS - 70) begin
					drain();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.pending_cells.size() != 0) begin
			tracker.failures++;
		end
		if (tracker.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
